/* design/cbz_pkg.sv */
// ============================================================================
// cbz_pkg: shared types and constants for the cubic Bezier point evaluator
// Holds the payload structs, the stage-to-stage control structs, the
// fixed-point widths, the register map and the long-division step.
// ============================================================================
package cbz_pkg;

  // Field widths of the interface.
  localparam int CoordW  = 20;
  localparam int StepW   = 8;
  localparam int CfgIdxW = 4;

  // Curve parameter u has 16 fraction bits and can reach exactly 1.0.
  localparam int FracU = 16;
  localparam int UW    = FracU + 1;

  // Number of control points and width of one Bernstein weight (32 fraction bits).
  localparam int NumCtrl = 4;
  localparam int WgtW    = 2 * FracU + 1;

  // Divider pipeline: quotient bits produced per stage.
  localparam int DivStages    = 4;
  localparam int BitsPerStage = FracU / DivStages;

  // Blend widths: one signed product, the sum of four, and the rounding point.
  localparam int ProdW      = CoordW + WgtW + 1;
  localparam int AccW       = ProdW + 2;
  localparam int RoundShift = 2 * FracU;

  // Cycles from an accepted start to the result strobe.
  localparam int Latency = 1 + DivStages + 3 + 3;

  // Register map of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_CTRL_X0 = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_CTRL_Y0 = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_CTRL_X1 = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_CTRL_Y1 = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_CTRL_X2 = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_CTRL_Y2 = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_CTRL_X3 = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_CTRL_Y3 = 4'd7;

  typedef logic signed [CoordW-1:0] cbz_coord_t;
  typedef cbz_coord_t [NumCtrl-1:0] cbz_ctrl_t;

  // Reset values of the control points.
  localparam cbz_coord_t RESET_X0 = 20'sd5120;
  localparam cbz_coord_t RESET_Y0 = 20'sd25600;
  localparam cbz_coord_t RESET_X1 = 20'sd7680;
  localparam cbz_coord_t RESET_Y1 = 20'sd28160;
  localparam cbz_coord_t RESET_X2 = 20'sd12800;
  localparam cbz_coord_t RESET_Y2 = 20'sd23040;
  localparam cbz_coord_t RESET_X3 = 20'sd15360;
  localparam cbz_coord_t RESET_Y3 = 20'sd25600;

  // Input item.
  typedef struct packed {
    logic [StepW-1:0] step_index;
    logic [StepW-1:0] step_count;
  } cbz_in_t;

  // Result item.
  typedef struct packed {
    cbz_coord_t point_x;
    cbz_coord_t point_y;
    logic       index_clamped;
  } cbz_out_t;

  // Divider to weight stage: quotient and flags.
  typedef struct packed {
    logic             valid;
    logic             clamped;
    logic             full;
    logic [FracU-1:0] quot;
  } cbz_div_t;

  // Weight stage to blend stage: the four Bernstein weights.
  typedef struct packed {
    logic                           valid;
    logic                           clamped;
    logic [NumCtrl-1:0][WgtW-1:0]   wgt;
  } cbz_wgt_t;

  // One restoring long-division step: shift the remainder in a zero bit and
  // subtract the divisor where it fits. Returns {quotient bit, new remainder}.
  function automatic logic [StepW:0] cbz_div_step(input logic [StepW-1:0] rem,
                                                  input logic [StepW-1:0] den);
    logic [StepW:0] dbl;
    logic [StepW:0] diff;
    dbl  = {rem, 1'b0};
    diff = dbl - {1'b0, den};
    if (dbl >= {1'b0, den}) begin
      return {1'b1, diff[StepW-1:0]};
    end else begin
      return {1'b0, dbl[StepW-1:0]};
    end
  endfunction

endpackage

/* design/cbz_divider.sv */
// ============================================================================
// cbz_divider: clamp and pipelined u = k/n division
// Clamps the step index to the step count, then forms the 16 quotient bits
// of (k << 16) / n in a restoring divider, four bits per pipeline stage.
// ============================================================================
module cbz_divider
  import cbz_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  cbz_in_t  in_item,
  output cbz_div_t div_out
);

  logic             valid_r   [DivStages+1];
  logic             clamped_r [DivStages+1];
  logic             full_r    [DivStages+1];
  logic [FracU-1:0] quot_r    [DivStages+1];
  logic [StepW-1:0] rem_r     [DivStages];
  logic [StepW-1:0] den_r     [DivStages];

  logic             over;
  logic [StepW-1:0] k_clamp;

  // Clamp an index beyond the count; k equal to n means u is exactly 1.0.
  assign over    = in_item.step_index > in_item.step_count;
  assign k_clamp = over ? in_item.step_count : in_item.step_index;

  // Entry stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  // Entry stage payload; the remainder starts at the clamped index.
  always_ff @(posedge clk) begin
    clamped_r[0] <= over;
    full_r[0]    <= (k_clamp == in_item.step_count);
    quot_r[0]    <= '0;
    rem_r[0]     <= k_clamp;
    den_r[0]     <= in_item.step_count;
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [StepW-1:0]        rem_nxt;
    logic [BitsPerStage-1:0] qbits_nxt;

    // Four dependent division steps on an 8-bit remainder.
    always_comb begin
      logic [StepW-1:0] rem;
      logic [StepW:0]   st;
      rem       = rem_r[s];
      st        = '0;
      qbits_nxt = '0;
      for (int b = 0; b < BitsPerStage; b++) begin
        st = cbz_div_step(rem, den_r[s]);
        qbits_nxt[BitsPerStage-1-b] = st[StepW];
        rem = st[StepW-1:0];
      end
      rem_nxt = rem;
    end

    // Stage valid.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else begin
        valid_r[s+1] <= valid_r[s];
      end
    end

    // Quotient bits enter at the bottom, most significant first.
    always_ff @(posedge clk) begin
      clamped_r[s+1] <= clamped_r[s];
      full_r[s+1]    <= full_r[s];
      quot_r[s+1]    <= {quot_r[s][FracU-BitsPerStage-1:0], qbits_nxt};
    end

    // The remainder and divisor are carried on to all but the last stage.
    if (s < DivStages - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[s+1] <= rem_nxt;
        den_r[s+1] <= den_r[s];
      end
    end
  end

  assign div_out.valid   = valid_r[DivStages];
  assign div_out.clamped = clamped_r[DivStages];
  assign div_out.full    = full_r[DivStages];
  assign div_out.quot    = quot_r[DivStages];

endmodule

/* design/cbz_weights.sv */
// ============================================================================
// cbz_weights: Bernstein weight pipeline
// Turns the quotient into u and v = 1 - u, then forms v^3, 3uv^2, 3u^2v and
// u^3 exactly and keeps 32 fraction bits of each, over three stages.
// ============================================================================
module cbz_weights
  import cbz_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cbz_div_t div_in,
  output cbz_wgt_t wgt_out
);

  localparam int SqW  = 2 * UW - 1;
  localparam int TriW = UW + 1;
  localparam int CubW = SqW + TriW;
  localparam logic [UW-1:0] OneU = UW'(1) << FracU;

  // Stage A: u and v.
  logic          a_valid_r, a_clamped_r;
  logic [UW-1:0] a_u_r, a_v_r;
  logic [UW-1:0] u_nxt;

  // Stage B: squares and triples.
  logic            b_valid_r, b_clamped_r;
  logic [UW-1:0]   b_u_r, b_v_r;
  logic [SqW-1:0]  b_uu_r, b_vv_r;
  logic [TriW-1:0] b_u3_r, b_v3_r;

  // Stage C: weights.
  logic                         c_valid_r, c_clamped_r;
  logic [NumCtrl-1:0][WgtW-1:0] c_wgt_r;
  logic [CubW-1:0]              p0_nxt, p1_nxt, p2_nxt, p3_nxt;

  assign u_nxt = div_in.full ? OneU : {1'b0, div_in.quot};

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= div_in.valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  // Stage A: u is exactly 1.0 when the clamped index reaches the count.
  always_ff @(posedge clk) begin
    a_clamped_r <= div_in.clamped;
    a_u_r       <= u_nxt;
    a_v_r       <= OneU - u_nxt;
  end

  // Stage B: one squaring multiplier each for u and v.
  always_ff @(posedge clk) begin
    b_clamped_r <= a_clamped_r;
    b_u_r       <= a_u_r;
    b_v_r       <= a_v_r;
    b_uu_r      <= SqW'(a_u_r) * SqW'(a_u_r);
    b_vv_r      <= SqW'(a_v_r) * SqW'(a_v_r);
    b_u3_r      <= TriW'(a_u_r) + {a_u_r, 1'b0};
    b_v3_r      <= TriW'(a_v_r) + {a_v_r, 1'b0};
  end

  // Stage C products: exact degree-three products with 48 fraction bits.
  always_comb begin
    p0_nxt = CubW'(b_vv_r) * CubW'(b_v_r);
    p1_nxt = CubW'(b_vv_r) * CubW'(b_u3_r);
    p2_nxt = CubW'(b_uu_r) * CubW'(b_v3_r);
    p3_nxt = CubW'(b_uu_r) * CubW'(b_u_r);
  end

  // Stage C: truncate each product to 32 fraction bits.
  always_ff @(posedge clk) begin
    c_clamped_r <= b_clamped_r;
    c_wgt_r[0]  <= p0_nxt[WgtW+FracU-1:FracU];
    c_wgt_r[1]  <= p1_nxt[WgtW+FracU-1:FracU];
    c_wgt_r[2]  <= p2_nxt[WgtW+FracU-1:FracU];
    c_wgt_r[3]  <= p3_nxt[WgtW+FracU-1:FracU];
  end

  assign wgt_out.valid   = c_valid_r;
  assign wgt_out.clamped = c_clamped_r;
  assign wgt_out.wgt     = c_wgt_r;

endmodule

/* design/cbz_blend.sv */
// ============================================================================
// cbz_blend: weighted sum, rounding and saturation
// Multiplies each control coordinate by its weight, sums the four terms per
// axis, rounds to 8 fraction bits and saturates to the 20-bit range.
// ============================================================================
module cbz_blend
  import cbz_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cbz_wgt_t  wgt_in,
  input  cbz_ctrl_t ctrl_x,
  input  cbz_ctrl_t ctrl_y,
  output logic      out_valid,
  output cbz_out_t  out_item
);

  localparam int RW = AccW - RoundShift;
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (RoundShift - 1);

  // Stage D: products.
  logic                          d_valid_r, d_clamped_r;
  logic signed [ProdW-1:0]       d_px_r [NumCtrl];
  logic signed [ProdW-1:0]       d_py_r [NumCtrl];
  logic signed [ProdW-1:0]       px_nxt [NumCtrl];
  logic signed [ProdW-1:0]       py_nxt [NumCtrl];

  // Stage E: rounded sums.
  logic                          e_valid_r, e_clamped_r;
  logic signed [AccW-1:0]        e_accx_r, e_accy_r;
  logic signed [AccW-1:0]        accx_nxt, accy_nxt;

  // Stage F: output register.
  logic                          out_valid_r;
  cbz_out_t                      out_item_r;
  logic signed [RW-1:0]          rx, ry;
  cbz_coord_t                    satx_nxt, saty_nxt;

  // Signed coordinate times unsigned weight, one multiplier per term.
  always_comb begin
    for (int i = 0; i < NumCtrl; i++) begin
      logic signed [CoordW-1:0] cx;
      logic signed [CoordW-1:0] cy;
      logic signed [WgtW:0]     ws;
      cx = $signed(ctrl_x[i]);
      cy = $signed(ctrl_y[i]);
      ws = $signed({1'b0, wgt_in.wgt[i]});
      px_nxt[i] = cx * ws;
      py_nxt[i] = cy * ws;
    end
  end

  // Sum of four terms with one half added at the rounding point.
  always_comb begin
    accx_nxt = AccW'(d_px_r[0]) + AccW'(d_px_r[1]) + AccW'(d_px_r[2])
             + AccW'(d_px_r[3]) + RoundHalf;
    accy_nxt = AccW'(d_py_r[0]) + AccW'(d_py_r[1]) + AccW'(d_py_r[2])
             + AccW'(d_py_r[3]) + RoundHalf;
  end

  // Floor to 8 fraction bits, then saturate where the upper bits disagree.
  always_comb begin
    rx = e_accx_r[AccW-1:RoundShift];
    ry = e_accy_r[AccW-1:RoundShift];
    if (rx[RW-1:CoordW-1] == {(RW-CoordW+1){rx[RW-1]}}) begin
      satx_nxt = rx[CoordW-1:0];
    end else begin
      satx_nxt = rx[RW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    if (ry[RW-1:CoordW-1] == {(RW-CoordW+1){ry[RW-1]}}) begin
      saty_nxt = ry[CoordW-1:0];
    end else begin
      saty_nxt = ry[RW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      d_valid_r   <= wgt_in.valid;
      e_valid_r   <= d_valid_r;
      out_valid_r <= e_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    d_clamped_r <= wgt_in.clamped;
    d_px_r      <= px_nxt;
    d_py_r      <= py_nxt;
    e_clamped_r <= d_clamped_r;
    e_accx_r    <= accx_nxt;
    e_accy_r    <= accy_nxt;
    out_item_r.point_x       <= satx_nxt;
    out_item_r.point_y       <= saty_nxt;
    out_item_r.index_clamped <= e_clamped_r;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* design/cubic_bezier_point_evaluator_top.sv */
// ============================================================================
// cubic_bezier_point_evaluator_top: cubic Bezier point evaluator
// Control point registers, the divider, weight and blend pipelines.
// ============================================================================
// A start transfer is taken on every cycle: busy stays low, and one point
// leaves on out_valid once its start transfer has passed one entry register,
// four divider stages of four quotient bits each, three weight stages and
// three blend stages, in the order the items came in. Each result is shown
// for a single cycle and cannot be held off. Configuration writes are always
// accepted (cfg_ready is always high); write the control points only while
// no item is in flight.
module cubic_bezier_point_evaluator_top
  import cbz_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cbz_in_t            in_item,
  output logic               out_valid,
  output cbz_out_t           out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CoordW-1:0]  cfg_data
);

  cbz_ctrl_t ctrl_x_r, ctrl_y_r;
  cbz_div_t  div_bus;
  cbz_wgt_t  wgt_bus;
  logic      in_xfer;

  // The pipeline never stalls, so every start is a transfer.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_xfer   = start && !busy;

  // Control point registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_x_r[0] <= RESET_X0;
      ctrl_y_r[0] <= RESET_Y0;
      ctrl_x_r[1] <= RESET_X1;
      ctrl_y_r[1] <= RESET_Y1;
      ctrl_x_r[2] <= RESET_X2;
      ctrl_y_r[2] <= RESET_Y2;
      ctrl_x_r[3] <= RESET_X3;
      ctrl_y_r[3] <= RESET_Y3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CTRL_X0: ctrl_x_r[0] <= cfg_data;
        REG_CTRL_Y0: ctrl_y_r[0] <= cfg_data;
        REG_CTRL_X1: ctrl_x_r[1] <= cfg_data;
        REG_CTRL_Y1: ctrl_y_r[1] <= cfg_data;
        REG_CTRL_X2: ctrl_x_r[2] <= cfg_data;
        REG_CTRL_Y2: ctrl_y_r[2] <= cfg_data;
        REG_CTRL_X3: ctrl_x_r[3] <= cfg_data;
        REG_CTRL_Y3: ctrl_y_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Curve parameter u = k/n.
  cbz_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_xfer),
    .in_item  (in_item),
    .div_out  (div_bus)
  );

  // Bernstein weights.
  cbz_weights u_weights (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_bus),
    .wgt_out (wgt_bus)
  );

  // Weighted sum of the control points.
  cbz_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .wgt_in    (wgt_bus),
    .ctrl_x    (ctrl_x_r),
    .ctrl_y    (ctrl_y_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* design/cbz_checker.sv */
// ============================================================================
// cbz_checker: port-level checks for the cubic Bezier point evaluator
// Checks the fixed latency between start and result transfers and the
// clamp flag against the input item that produced it, and the flush on reset.
// ============================================================================
module cbz_checker
  import cbz_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input cbz_in_t  in_item,
  input logic     out_valid,
  input cbz_out_t out_item
);

  // Every start transfer produces a result after the fixed latency.
  a_start_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_valid)
    else $error("start transfer not followed by a result");

  // No result appears without a start transfer the fixed latency earlier.
  a_result_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, Latency))
    else $error("result without a matching start transfer");

  // The clamp flag matches the index and count of the producing item.
  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.index_clamped ==
      ($past(in_item.step_index, Latency) > $past(in_item.step_count, Latency))))
    else $error("index_clamped does not match the input item");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind cubic_bezier_point_evaluator_top cbz_checker u_cbz_checker (.*);
